/* design/timer_event_table_top_defines.svh */
// ----------------------------------------------------------------------------
// Timer event table assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TIMER_EVENT_TABLE_TOP_DEFINES_SVH
`define TIMER_EVENT_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TET_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer event table check failed");

// Delayed implication, sampled on clock, off during reset.
`define TET_ASSERT_DLY2(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error("timer event table check failed");

`endif

/* design/tet_pkg.sv */
// ----------------------------------------------------------------------------
// Timer event table package
// Payload types, codes, controller interface and shared helpers.
// ----------------------------------------------------------------------------
package tet_pkg;

   localparam int TIME_W = 48;
   localparam int TABLE_DEPTH_DEF = 16;
   localparam logic [31:0] IDLE_DELAY_RESET = 32'd300000;

   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_ADD_ONE = 2'd1;
   localparam logic [1:0] KIND_ADD_PER = 2'd2;

   localparam logic [1:0] EV_FIRED      = 2'd0;
   localparam logic [1:0] EV_TICK_DONE  = 2'd1;
   localparam logic [1:0] EV_ADDED      = 2'd2;
   localparam logic [1:0] EV_TABLE_FULL = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TIME_W-1:0] now;
      logic [7:0]        task_id;
      logic [TIME_W-1:0] due_time;
      logic [31:0]       interval;
      logic [TIME_W-1:0] until_req;
   } req_type;

   typedef struct packed {
      logic [1:0]        event_res;
      logic [7:0]        fired_task;
      logic [TIME_W-1:0] next_wake;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_SEL_INIT,
      ST_SEL_SCAN,
      ST_SEL_TAIL,
      ST_SEL_APPLY,
      ST_RET_INIT,
      ST_RET_SCAN,
      ST_RET_TAIL,
      ST_WAKE_A,
      ST_WAKE_B,
      ST_EMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic tick_init;
      logic add_exec;
      logic scan_clear;
      logic scan_issue;
      logic mode_retire;
      logic sel_apply;
      logic wake_a;
      logic wake_b;
      logic emit_fire;
      logic emit_done;
   } cmd_type;

   typedef struct packed {
      logic best_found;
      logic want_per;
      logic scan_last;
      logic fire_none;
      logic emit_last;
   } sts_type;

   // Time sum that saturates at the top of the 48-bit range.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

/* design/tet_ctrl.sv */
// ----------------------------------------------------------------------------
// Timer event table controller
// Sequences add, fire selection, retirement, wake update and result output.
// ----------------------------------------------------------------------------
module tet_ctrl
   import tet_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] kind,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               if (kind == KIND_TICK) begin
                  cmd.tick_init = 1'b1;
                  state_in      = ST_SEL_INIT;
               end else if (kind == KIND_ADD_ONE || kind == KIND_ADD_PER) begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            cmd.add_exec = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SEL_INIT: begin
            cmd.scan_clear = 1'b1;
            state_in       = ST_SEL_SCAN;
         end
         ST_SEL_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) state_in = ST_SEL_TAIL;
         end
         ST_SEL_TAIL: begin
            state_in = ST_SEL_APPLY;
         end
         ST_SEL_APPLY: begin
            cmd.sel_apply = 1'b1;
            // With nothing left to fire, the periodic pass hands over to the
            // one-shot pass, and the one-shot pass ends the selection.
            if (sts.best_found || sts.want_per) state_in = ST_SEL_INIT;
            else state_in = ST_RET_INIT;
         end
         ST_RET_INIT: begin
            cmd.scan_clear = 1'b1;
            state_in       = ST_RET_SCAN;
         end
         ST_RET_SCAN: begin
            cmd.scan_issue  = 1'b1;
            cmd.mode_retire = 1'b1;
            if (sts.scan_last) state_in = ST_RET_TAIL;
         end
         ST_RET_TAIL: begin
            cmd.mode_retire = 1'b1;
            state_in        = ST_WAKE_A;
         end
         ST_WAKE_A: begin
            cmd.wake_a = 1'b1;
            state_in   = ST_WAKE_B;
         end
         ST_WAKE_B: begin
            cmd.wake_b = 1'b1;
            state_in   = sts.fire_none ? ST_DONE : ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_fire = 1'b1;
            if (sts.emit_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.emit_done = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/tet_dpath.sv */
// ----------------------------------------------------------------------------
// Timer event table datapath
// Slot memories, scan compare logic, fire buffer, wake time and result register.
// ----------------------------------------------------------------------------
module tet_dpath
   import tet_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [TIME_W-1:0] due_mem    [TABLE_DEPTH];
   logic [31:0]       period_mem [TABLE_DEPTH];
   logic [TIME_W-1:0] expiry_mem [TABLE_DEPTH];
   logic [7:0]        task_mem   [TABLE_DEPTH];
   logic              per_mem    [TABLE_DEPTH];
   logic [7:0]        fire_mem   [TABLE_DEPTH];

   req_type            req_ff;
   logic [31:0]        idle_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, done_ff;
   logic               want_per_ff;
   logic [IDX_W-1:0]   scan_cnt_ff;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [TIME_W-1:0]  rd_due_ff, rd_exp_ff;
   logic [31:0]        rd_period_ff;
   logic [7:0]         rd_task_ff;
   logic               rd_per_ff;
   logic               best_found_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [TIME_W-1:0]  best_due_ff;
   logic [31:0]        best_period_ff;
   logic [7:0]         best_task_ff;
   logic               have_one_ff, have_per_ff;
   logic [TIME_W-1:0]  one_min_ff, per_min_ff, cand_ff, wake_ff;
   logic [CNT_W-1:0]   fire_cnt_ff;
   logic [IDX_W-1:0]   emit_ptr_ff;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff;

   logic               free_found;
   logic [IDX_W-1:0]   free_idx;
   logic [TIME_W-1:0]  add_due, add_wake, adv_due, idle_sum;
   logic               add_ok, apply_do, sel_hit, ret_kill, ret_per, ret_one, rd_live;

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign add_due  = (req_ff.kind == KIND_ADD_ONE) ? req_ff.due_time
                   : sat_add(req_ff.now, {16'd0, req_ff.interval});
   assign add_wake = (add_due < wake_ff) ? add_due : wake_ff;
   assign add_ok   = cmd.add_exec && free_found;
   assign apply_do = cmd.sel_apply && best_found_ff;
   assign adv_due  = sat_add(best_due_ff, {16'd0, best_period_ff});
   assign idle_sum = sat_add(req_ff.now, {16'd0, idle_ff});

   assign rd_live  = rd_vld_ff && valid_ff[rd_idx_ff];
   assign sel_hit  = rd_live && !cmd.mode_retire && (rd_per_ff == want_per_ff)
                   && !done_ff[rd_idx_ff] && (rd_due_ff <= req_ff.now)
                   && (!best_found_ff || rd_due_ff < best_due_ff);
   assign ret_kill = rd_live && cmd.mode_retire && rd_per_ff && (rd_exp_ff <= req_ff.now);
   assign ret_per  = rd_live && cmd.mode_retire && rd_per_ff && !ret_kill;
   assign ret_one  = rd_live && cmd.mode_retire && !rd_per_ff;

   // Memories, read data and payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.scan_issue) begin
         rd_due_ff    <= due_mem[scan_cnt_ff];
         rd_exp_ff    <= expiry_mem[scan_cnt_ff];
         rd_period_ff <= period_mem[scan_cnt_ff];
         rd_task_ff   <= task_mem[scan_cnt_ff];
         rd_per_ff    <= per_mem[scan_cnt_ff];
      end
      rd_idx_ff <= scan_cnt_ff;
      if (add_ok) begin
         due_mem[free_idx]    <= add_due;
         period_mem[free_idx] <= req_ff.interval;
         expiry_mem[free_idx] <= req_ff.until_req;
         task_mem[free_idx]   <= req_ff.task_id;
         per_mem[free_idx]    <= (req_ff.kind == KIND_ADD_PER);
      end else if (apply_do && want_per_ff) begin
         due_mem[best_idx_ff] <= adv_due;
      end
      if (apply_do) fire_mem[fire_cnt_ff[IDX_W-1:0]] <= best_task_ff;
      if (sel_hit) begin
         best_idx_ff    <= rd_idx_ff;
         best_due_ff    <= rd_due_ff;
         best_period_ff <= rd_period_ff;
         best_task_ff   <= rd_task_ff;
      end
      if (ret_per && (!have_per_ff || rd_due_ff < per_min_ff)) per_min_ff <= rd_due_ff;
      if (ret_one && (!have_one_ff || rd_due_ff < one_min_ff)) one_min_ff <= rd_due_ff;
      if (cmd.wake_a) cand_ff <= have_one_ff ? one_min_ff : idle_sum;
      if (add_ok) begin
         rsp_ff <= '{event_res: EV_ADDED, fired_task: req_ff.task_id,
                     next_wake: add_wake, last: 1'b1};
      end else if (cmd.add_exec) begin
         rsp_ff <= '{event_res: EV_TABLE_FULL, fired_task: req_ff.task_id,
                     next_wake: wake_ff, last: 1'b1};
      end else if (cmd.emit_fire) begin
         rsp_ff <= '{event_res: EV_FIRED, fired_task: fire_mem[emit_ptr_ff],
                     next_wake: wake_ff, last: 1'b0};
      end else if (cmd.emit_done) begin
         rsp_ff <= '{event_res: EV_TICK_DONE, fired_task: 8'd0,
                     next_wake: wake_ff, last: 1'b1};
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff       <= IDLE_DELAY_RESET;
         valid_ff      <= '0;
         done_ff       <= '0;
         want_per_ff   <= 1'b1;
         scan_cnt_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         have_one_ff   <= 1'b0;
         have_per_ff   <= 1'b0;
         wake_ff       <= '0;
         fire_cnt_ff   <= '0;
         emit_ptr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) idle_ff <= csr_wdata;
         rd_vld_ff     <= cmd.scan_issue;
         rsp_strobe_ff <= cmd.add_exec || cmd.emit_fire || cmd.emit_done;
         if (cmd.tick_init) begin
            done_ff     <= '0;
            want_per_ff <= 1'b1;
            fire_cnt_ff <= '0;
            emit_ptr_ff <= '0;
         end
         if (cmd.scan_clear) begin
            scan_cnt_ff   <= '0;
            best_found_ff <= 1'b0;
            have_one_ff   <= 1'b0;
            have_per_ff   <= 1'b0;
         end else if (cmd.scan_issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (sel_hit) best_found_ff <= 1'b1;
         if (ret_per) have_per_ff <= 1'b1;
         if (ret_one) have_one_ff <= 1'b1;
         if (add_ok) begin
            valid_ff[free_idx] <= 1'b1;
            wake_ff            <= add_wake;
         end
         if (apply_do) begin
            done_ff[best_idx_ff] <= 1'b1;
            fire_cnt_ff          <= fire_cnt_ff + 1'b1;
            if (!want_per_ff) valid_ff[best_idx_ff] <= 1'b0;
         end else if (cmd.sel_apply) begin
            want_per_ff <= 1'b0;
         end
         if (ret_kill) valid_ff[rd_idx_ff] <= 1'b0;
         if (cmd.wake_b) begin
            wake_ff <= (have_per_ff && per_min_ff < cand_ff) ? per_min_ff : cand_ff;
         end
         if (cmd.emit_fire) emit_ptr_ff <= emit_ptr_ff + 1'b1;
      end
   end

   assign sts.best_found = best_found_ff;
   assign sts.want_per   = want_per_ff;
   assign sts.scan_last  = (scan_cnt_ff == IDX_W'(TABLE_DEPTH - 1));
   assign sts.fire_none  = (fire_cnt_ff == '0);
   assign sts.emit_last  = ({1'b0, emit_ptr_ff} == (IDX_W + 1)'(fire_cnt_ff - 1'b1));

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* design/timer_event_table_top.sv */
// ----------------------------------------------------------------------------
// Timer event table top level
// Timer entry table with add and tick commands, built as controller plus datapath.
// ----------------------------------------------------------------------------
// Add: a single result, registered after the add step; busy during that step.
// Tick: each fire-selection scan walks the slot memories, one slot memory
//   read per cycle; F fires cost (F+2) scans, then a retire scan, two wake
//   steps and F+1 results (one per cycle).
// The receiver cannot stall; each result is shown for one cycle.
// Reset clears all slots and the wake time and sets the idle delay to 300000.
module timer_event_table_top
   import tet_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   tet_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_data.kind),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   tet_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

/* design/tet_checker.sv */
// ----------------------------------------------------------------------------
// Timer event table checker
// Port-level properties of the command and result transfers.
// ----------------------------------------------------------------------------
`include "timer_event_table_top_defines.svh"

module tet_checker
   import tet_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // An accepted add always answers with a single final result.
   `TET_ASSERT_DLY2(a_add_answers, start && !busy && (req_data.kind == KIND_ADD_ONE || req_data.kind == KIND_ADD_PER), rsp_strobe && rsp_data.last)

   // The final result of an item is only shown once the block is free again.
   `TET_ASSERT_IMP(a_last_idle, rsp_strobe && rsp_data.last, !busy)

   // Fired results are never the final result of a tick.
   `TET_ASSERT_IMP(a_fired_not_last, rsp_strobe && rsp_data.event_res == EV_FIRED, !rsp_data.last)

   // The tick-done result carries no task id.
   `TET_ASSERT_IMP(a_done_task, rsp_strobe && rsp_data.event_res == EV_TICK_DONE, rsp_data.fired_task == 8'd0 && rsp_data.last)

endmodule

bind timer_event_table_top tet_checker u_tet_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
